@@ rtl/core/hmsu_pkg.sv @@
`default_nettype none

package hmsu_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int WORD_BITS_DEF = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int MASS_BITS     = 25;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NEG_DISC   = 2'd1,
        ST_ON_PRIMARY = 2'd2
    } status_t;

    typedef enum logic {
        REG_MASS_RATIO = 1'b0,
        REG_ENERGY     = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/core/hamiltonian_momentum_solver_unit.sv @@
`default_nettype none

// Pipeline depth (Q8.24 by default): two bit-per-stage root units and one
//          bit-per-stage divider set the depth.
// Throughput: one point per cycle; busy stays low, done strobes for one cycle.
// Reset (rst_n low, async): all valid bits clear, mass_ratio and energy go to 0.
module hamiltonian_momentum_solver_unit #(
    parameter int FRAC_BITS = hmsu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = hmsu_pkg::WORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command side
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [WORD_BITS-1:0]         x_pos,
    input  wire logic signed [WORD_BITS-1:0]         y_pos,
    input  wire logic signed [WORD_BITS-1:0]         x_momentum,
    // result side
    output logic                                     done,
    output logic signed [WORD_BITS-1:0]              y_momentum,
    output logic [1:0]                               status,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hmsu_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [hmsu_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [hmsu_pkg::CFG_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    // root unit: radicand v<<F padded to an even width
    localparam int SQ_K = (W + F + 1) / 2;
    localparam int SQ_N = 2 * SQ_K;
    // divider numerator: mass<<F plus half the distance
    localparam int DIV_NB = ((2*F + 1 > W) ? 2*F + 1 : W) + 1;
    localparam int LATENCY = 3 + 2*SQ_K + DIV_NB + 4;

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [64:0]  E_HI = $signed({{(66-W){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [64:0]  E_LO = $signed({{(66-W){1'b1}}, {(W-1){1'b0}}});

    function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W:0] ext(input logic signed [W-1:0] a);
        return $signed({a[W-1], a});
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Write only while the pipe is empty; not enforced here.
    // ------------------------------------------------------------------
    logic [hmsu_pkg::MASS_BITS-1:0]     mass_reg;
    logic [hmsu_pkg::CFG_DATA_BITS-1:0] energy_reg;
    logic                               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= '0;
            energy_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (hmsu_pkg::cfg_reg_t'(paddr[2]))
                hmsu_pkg::REG_MASS_RATIO: mass_reg   <= pwdata[hmsu_pkg::MASS_BITS-1:0];
                hmsu_pkg::REG_ENERGY:     energy_reg <= pwdata;
                default:                  mass_reg   <= mass_reg;
            endcase
        end
    end

    always_comb
    begin
        case (hmsu_pkg::cfg_reg_t'(paddr[2]))
            hmsu_pkg::REG_MASS_RATIO:
                prdata = hmsu_pkg::CFG_DATA_BITS'(mass_reg);
            hmsu_pkg::REG_ENERGY:
                prdata = energy_reg;
            default:
                prdata = '0;
        endcase
    end

    // mu clamps at 1.0 so the second mass 1-mu never goes negative
    logic [64:0]         mass_ext;
    logic [64:0]         one_ext;
    logic [F:0]          mu;
    logic [F:0]          mu2;
    logic signed [64:0]  e_ext;
    logic signed [W-1:0] energy_w;

    assign mass_ext = 65'(mass_reg);
    assign one_ext  = 65'(1) << F;
    assign mu       = (mass_ext > one_ext) ? (F+1)'(one_ext) : (F+1)'(mass_ext);
    assign mu2      = (F+1)'(one_ext) - mu;
    assign e_ext    = $signed({{33{energy_reg[31]}}, energy_reg});
    assign energy_w = (e_ext > E_HI) ? WMAX : (e_ext < E_LO) ? WMIN : e_ext[W-1:0];

    // ------------------------------------------------------------------
    // Front: offsets to both primaries, squares and the px terms.
    // ------------------------------------------------------------------
    logic                fr_vld;
    logic signed [W-1:0] fr_sq1, fr_sq2, fr_ca, fr_xsq, fr_x;
    logic [F:0]          fr_mu, fr_mu2;

    assign busy = 1'b0;

    hmsu_front #(
        .W(W),
        .F(F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .x         (x_pos),
        .y         (y_pos),
        .px        (x_momentum),
        .mu        (mu),
        .mu2       (mu2),
        .out_valid (fr_vld),
        .sq1       (fr_sq1),
        .sq2       (fr_sq2),
        .ca        (fr_ca),
        .xsq       (fr_xsq),
        .x_out     (fr_x),
        .mu_out    (fr_mu),
        .mu2_out   (fr_mu2)
    );

    // ------------------------------------------------------------------
    // Distances r1, r2: two root units side by side, same latency.
    // Unit 1 carries x, x^2 and the px terms; unit 2 carries the masses.
    // ------------------------------------------------------------------
    logic              d1_vld, d2_vld;
    logic [SQ_K-1:0]   root1, root2;
    logic [3*W-1:0]    d1_side;
    logic [2*F+1:0]    d2_side;

    hmsu_sqrt_pipe #(
        .N (SQ_N),
        .SW(3*W)
    ) u_dist1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_vld),
        .rad       (SQ_N'({fr_sq1, {F{1'b0}}})),
        .side_in   ({fr_x, fr_xsq, fr_ca}),
        .out_valid (d1_vld),
        .root      (root1),
        .side_out  (d1_side)
    );

    hmsu_sqrt_pipe #(
        .N (SQ_N),
        .SW(2*F+2)
    ) u_dist2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_vld),
        .rad       (SQ_N'({fr_sq2, {F{1'b0}}})),
        .side_in   ({fr_mu, fr_mu2}),
        .out_valid (d2_vld),
        .root      (root2),
        .side_out  (d2_side)
    );

    logic [SQ_K+W-1:0] root1_x, root2_x, wmax_x;
    logic [W-1:0]      r1, r2;
    logic [F:0]        d_mu, d_mu2;
    logic              z1, z2;

    assign wmax_x  = (SQ_K+W)'(WMAX);
    assign root1_x = (SQ_K+W)'(root1);
    assign root2_x = (SQ_K+W)'(root2);
    assign r1      = (root1_x > wmax_x) ? WMAX : W'(root1_x);
    assign r2      = (root2_x > wmax_x) ? WMAX : W'(root2_x);
    assign z1      = (r1 == '0);
    assign z2      = (r2 == '0);
    assign d_mu    = d2_side[2*F+1 -: F+1];
    assign d_mu2   = d2_side[F:0];

    // ------------------------------------------------------------------
    // Potential terms mu/r1 and (1-mu)/r2, rounded quotients.
    // A zero distance divides by zero here; the flag overrides the term.
    // ------------------------------------------------------------------
    logic              q1_vld, q2_vld;
    logic [DIV_NB-1:0] quot1, quot2;
    logic [3*W-1:0]    q1_side;
    logic [1:0]        q2_side;

    hmsu_div_pipe #(
        .NB(DIV_NB),
        .W (W),
        .SW(3*W)
    ) u_pot1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_vld && d2_vld),
        .num       (DIV_NB'({d_mu, {F{1'b0}}}) + DIV_NB'(r1 >> 1)),
        .den       (r1),
        .side_in   (d1_side),
        .out_valid (q1_vld),
        .quot      (quot1),
        .side_out  (q1_side)
    );

    hmsu_div_pipe #(
        .NB(DIV_NB),
        .W (W),
        .SW(2)
    ) u_pot2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_vld && d2_vld),
        .num       (DIV_NB'({d_mu2, {F{1'b0}}}) + DIV_NB'(r2 >> 1)),
        .den       (r2),
        .side_in   ({z1, z2}),
        .out_valid (q2_vld),
        .quot      (quot2),
        .side_out  (q2_side)
    );

    logic [DIV_NB+W-1:0] quot1_x, quot2_x, qmax_x;
    logic signed [W-1:0] t1, t2;

    assign qmax_x  = (DIV_NB+W)'(WMAX);
    assign quot1_x = (DIV_NB+W)'(quot1);
    assign quot2_x = (DIV_NB+W)'(quot2);
    assign t1 = (q2_side[1] || quot1_x > qmax_x) ? WMAX : W'(quot1_x);
    assign t2 = (q2_side[0] || quot2_x > qmax_x) ? WMAX : W'(quot2_x);

    // ------------------------------------------------------------------
    // c and the discriminant, three stages of saturating adds.
    // ------------------------------------------------------------------
    logic                vld_d1_reg, vld_d2_reg, vld_d3_reg;
    logic signed [W-1:0] x_d1_reg, x_d2_reg, x_d3_reg;
    logic signed [W-1:0] xsq_d1_reg, xsq_d2_reg;
    logic signed [W-1:0] c1_reg, t2_d1_reg, c3_reg, disc_reg;
    logic                zp_d1_reg, zp_d2_reg;
    hmsu_pkg::status_t   st_d3_reg;
    logic signed [W-1:0] c2, dbl, disc;

    assign c2   = sat_sum(ext(c1_reg) - ext(t2_d1_reg));
    assign dbl  = sat_sum(ext(c3_reg) + ext(c3_reg));
    assign disc = sat_sum(ext(xsq_d2_reg) - ext(dbl));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d1_reg <= 1'b0;
            vld_d2_reg <= 1'b0;
            vld_d3_reg <= 1'b0;
        end
        else
        begin
            vld_d1_reg <= q1_vld && q2_vld;
            vld_d2_reg <= vld_d1_reg;
            vld_d3_reg <= vld_d2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_d1_reg   <= q1_side[3*W-1 -: W];
        xsq_d1_reg <= q1_side[2*W-1 -: W];
        c1_reg     <= sat_sum(ext(q1_side[W-1:0]) - ext(t1));
        t2_d1_reg  <= t2;
        zp_d1_reg  <= q2_side[1] || q2_side[0];

        x_d2_reg   <= x_d1_reg;
        xsq_d2_reg <= xsq_d1_reg;
        c3_reg     <= sat_sum(ext(c2) - ext(energy_w));
        zp_d2_reg  <= zp_d1_reg;

        x_d3_reg   <= x_d2_reg;
        // a point on a primary outranks a negative discriminant
        if (zp_d2_reg)
            st_d3_reg <= hmsu_pkg::ST_ON_PRIMARY;
        else if (disc[W-1])
            st_d3_reg <= hmsu_pkg::ST_NEG_DISC;
        else
            st_d3_reg <= hmsu_pkg::ST_OK;
        disc_reg   <= disc[W-1] ? '0 : disc;
    end

    // ------------------------------------------------------------------
    // sqrt(disc), then py = x - sqrt(disc) into the output register.
    // ------------------------------------------------------------------
    logic              rt_vld;
    logic [SQ_K-1:0]   root3;
    logic [W+1:0]      rt_side;
    logic [SQ_K+W-1:0] root3_x;
    logic signed [W-1:0] s_root;
    logic signed [W-1:0] rt_x;
    hmsu_pkg::status_t   rt_st;

    hmsu_sqrt_pipe #(
        .N (SQ_N),
        .SW(W+2)
    ) u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_d3_reg),
        .rad       (SQ_N'({disc_reg, {F{1'b0}}})),
        .side_in   ({x_d3_reg, st_d3_reg}),
        .out_valid (rt_vld),
        .root      (root3),
        .side_out  (rt_side)
    );

    assign root3_x = (SQ_K+W)'(root3);
    assign s_root  = (root3_x > wmax_x) ? WMAX : W'(root3_x);
    assign rt_x    = rt_side[W+1 -: W];
    assign rt_st   = hmsu_pkg::status_t'(rt_side[1:0]);

    logic                done_reg;
    logic signed [W-1:0] py_reg;
    logic [1:0]          status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rt_vld;
    end

    always_ff @(posedge clk)
    begin
        py_reg     <= (rt_st == hmsu_pkg::ST_OK) ? sat_sum(ext(rt_x) - ext(s_root)) : '0;
        status_reg <= rt_st;
    end

    assign done       = done_reg;
    assign y_momentum = py_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/hmsu_front.sv @@
`default_nettype none

// Three stages: offsets, six products, rounding and sums.
module hmsu_front #(
    parameter int W = hmsu_pkg::WORD_BITS_DEF,
    parameter int F = hmsu_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] x,
    input  wire logic signed [W-1:0] y,
    input  wire logic signed [W-1:0] px,
    input  wire logic        [F:0]   mu,
    input  wire logic        [F:0]   mu2,
    output logic                     out_valid,
    output logic signed [W-1:0]      sq1,
    output logic signed [W-1:0]      sq2,
    output logic signed [W-1:0]      ca,
    output logic signed [W-1:0]      xsq,
    output logic signed [W-1:0]      x_out,
    output logic        [F:0]        mu_out,
    output logic        [F:0]        mu2_out
);

    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [2*W:0] HI = $signed({{(W+2){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [2*W:0] LO = $signed({{(W+2){1'b1}}, {(W-1){1'b0}}});

    function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
        if (s[W] != s[W-1])
            return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W:0] ext(input logic signed [W-1:0] a);
        return $signed({a[W-1], a});
    endfunction

    // round to nearest, ties up; extra shifts one more bit (the halving)
    function automatic logic signed [W-1:0] rnd_sat(input logic signed [2*W-1:0] p,
                                                    input logic extra);
        logic signed [2*W:0] e;
        logic signed [2*W:0] q;
        e = $signed({p[2*W-1], p}) + $signed((2*W+1)'(1) << (extra ? F : F-1));
        q = extra ? (e >>> (F+1)) : (e >>> F);
        if (q > HI)
            return WMAX;
        if (q < LO)
            return WMIN;
        return q[W-1:0];
    endfunction

    logic                vld_a_reg, vld_b_reg, vld_c_reg;
    logic signed [W-1:0] x_a_reg, y_a_reg, px_a_reg, dx1_a_reg, dx2_a_reg;
    logic        [F:0]   mu_a_reg, mu2_a_reg, mu_b_reg, mu2_b_reg, mu_c_reg, mu2_c_reg;
    logic signed [W-1:0] x_b_reg, x_c_reg;
    logic signed [2*W-1:0] p_dx1_reg, p_dx2_reg, p_yy_reg, p_pp_reg, p_yp_reg, p_xx_reg;
    logic signed [W-1:0] sq1_reg, sq2_reg, ca_reg, xsq_reg;
    logic signed [W:0]   mu_ext, mu2_ext;

    assign mu_ext  = $signed({{(W-F){1'b0}}, mu});
    assign mu2_ext = $signed({{(W-F){1'b0}}, mu2});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_a_reg   <= x;
        y_a_reg   <= y;
        px_a_reg  <= px;
        mu_a_reg  <= mu;
        mu2_a_reg <= mu2;
        dx1_a_reg <= sat_sum(ext(x) - mu2_ext);
        dx2_a_reg <= sat_sum(ext(x) + mu_ext);

        x_b_reg   <= x_a_reg;
        mu_b_reg  <= mu_a_reg;
        mu2_b_reg <= mu2_a_reg;
        p_dx1_reg <= dx1_a_reg * dx1_a_reg;
        p_dx2_reg <= dx2_a_reg * dx2_a_reg;
        p_yy_reg  <= y_a_reg * y_a_reg;
        p_pp_reg  <= px_a_reg * px_a_reg;
        p_yp_reg  <= y_a_reg * px_a_reg;
        p_xx_reg  <= x_a_reg * x_a_reg;

        x_c_reg   <= x_b_reg;
        mu_c_reg  <= mu_b_reg;
        mu2_c_reg <= mu2_b_reg;
        sq1_reg   <= sat_sum(ext(rnd_sat(p_dx1_reg, 1'b0)) + ext(rnd_sat(p_yy_reg, 1'b0)));
        sq2_reg   <= sat_sum(ext(rnd_sat(p_dx2_reg, 1'b0)) + ext(rnd_sat(p_yy_reg, 1'b0)));
        ca_reg    <= sat_sum(ext(rnd_sat(p_pp_reg, 1'b1)) + ext(rnd_sat(p_yp_reg, 1'b0)));
        xsq_reg   <= rnd_sat(p_xx_reg, 1'b0);
    end

    assign out_valid = vld_c_reg;
    assign sq1       = sq1_reg;
    assign sq2       = sq2_reg;
    assign ca        = ca_reg;
    assign xsq       = xsq_reg;
    assign x_out     = x_c_reg;
    assign mu_out    = mu_c_reg;
    assign mu2_out   = mu2_c_reg;

endmodule

`default_nettype wire

@@ rtl/core/hmsu_sqrt_pipe.sv @@
`default_nettype none

// Integer square root, one root bit per stage.
module hmsu_sqrt_pipe #(
    parameter int N  = 56,
    parameter int SW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [N-1:0]    rad,
    input  wire logic [SW-1:0]   side_in,
    output logic                 out_valid,
    output logic [N/2-1:0]       root,
    output logic [SW-1:0]        side_out
);

    localparam int K = N / 2;

    logic [N-1:0]  rad_reg  [1:K];
    logic [K:0]    rem_reg  [1:K];
    logic [K-1:0]  q_reg    [1:K];
    logic [SW-1:0] side_reg [1:K];
    logic          vld_reg  [1:K];

    for (genvar i = 1; i <= K; i++)
    begin : g_stage
        logic [N-1:0]  rad_p;
        logic [K:0]    rem_p;
        logic [K-1:0]  q_p;
        logic [SW-1:0] side_p;
        logic          vld_p;
        logic [K+2:0]  cand;
        logic [K+2:0]  trial;
        logic          ge;

        if (i == 1)
        begin : g_first
            assign rad_p  = rad;
            assign rem_p  = '0;
            assign q_p    = '0;
            assign side_p = side_in;
            assign vld_p  = in_valid;
        end
        else
        begin : g_next
            assign rad_p  = rad_reg[i-1];
            assign rem_p  = rem_reg[i-1];
            assign q_p    = q_reg[i-1];
            assign side_p = side_reg[i-1];
            assign vld_p  = vld_reg[i-1];
        end

        assign cand  = {rem_p, rad_p[N-1 -: 2]};
        assign trial = {1'b0, q_p, 2'b01};
        assign ge    = cand >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= rad_p << 2;
            rem_reg[i]  <= ge ? (K+1)'(cand - trial) : cand[K:0];
            q_reg[i]    <= {q_p[K-2:0], ge};
            side_reg[i] <= side_p;
        end
    end

    assign out_valid = vld_reg[K];
    assign root      = q_reg[K];
    assign side_out  = side_reg[K];

endmodule

`default_nettype wire

@@ rtl/core/hmsu_div_pipe.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage.
module hmsu_div_pipe #(
    parameter int NB = 50,
    parameter int W  = 32,
    parameter int SW = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [NB-1:0]  num,
    input  wire logic [W-1:0]   den,
    input  wire logic [SW-1:0]  side_in,
    output logic                out_valid,
    output logic [NB-1:0]       quot,
    output logic [SW-1:0]       side_out
);

    logic [NB-1:0] num_reg  [1:NB];
    logic [W-1:0]  rem_reg  [1:NB];
    logic [NB-1:0] q_reg    [1:NB];
    logic [W-1:0]  den_reg  [1:NB];
    logic [SW-1:0] side_reg [1:NB];
    logic          vld_reg  [1:NB];

    for (genvar i = 1; i <= NB; i++)
    begin : g_stage
        logic [NB-1:0] num_p;
        logic [W-1:0]  rem_p;
        logic [NB-1:0] q_p;
        logic [W-1:0]  den_p;
        logic [SW-1:0] side_p;
        logic          vld_p;
        logic [W:0]    sh;
        logic [W:0]    dif;
        logic          ge;

        if (i == 1)
        begin : g_first
            assign num_p  = num;
            assign rem_p  = '0;
            assign q_p    = '0;
            assign den_p  = den;
            assign side_p = side_in;
            assign vld_p  = in_valid;
        end
        else
        begin : g_next
            assign num_p  = num_reg[i-1];
            assign rem_p  = rem_reg[i-1];
            assign q_p    = q_reg[i-1];
            assign den_p  = den_reg[i-1];
            assign side_p = side_reg[i-1];
            assign vld_p  = vld_reg[i-1];
        end

        assign sh  = {rem_p, num_p[NB-1]};
        assign ge  = sh >= {1'b0, den_p};
        assign dif = sh - {1'b0, den_p};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_p;
        end

        always_ff @(posedge clk)
        begin
            num_reg[i]  <= num_p << 1;
            rem_reg[i]  <= ge ? dif[W-1:0] : sh[W-1:0];
            q_reg[i]    <= {q_p[NB-2:0], ge};
            den_reg[i]  <= den_p;
            side_reg[i] <= side_p;
        end
    end

    assign out_valid = vld_reg[NB];
    assign quot      = q_reg[NB];
    assign side_out  = side_reg[NB];

endmodule

`default_nettype wire

@@ rtl/core/hmsu_checker.sv @@
`default_nettype none

module hmsu_assertions #(
    parameter int W   = hmsu_pkg::WORD_BITS_DEF,
    parameter int LAT = 113
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic signed [W-1:0] y_momentum,
    input wire logic [1:0]          status
);

    // no backpressure: the unit always takes a command
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // each result traces back to an earlier command transfer
    a_done_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching command");

    // failed solves report zero momentum
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != hmsu_pkg::ST_OK) |-> (y_momentum == '0))
        else $error("nonzero momentum on failed solve");

endmodule

bind hamiltonian_momentum_solver_unit hmsu_assertions #(
    .W  (WORD_BITS),
    .LAT(LATENCY)
) u_hmsu_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .y_momentum (y_momentum),
    .status     (status)
);

`default_nettype wire

@@ dv/hmsu_checker.sv @@
`timescale 1ns / 1ps

module hmsu_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] x_pos,
    input  logic signed [31:0] y_pos,
    input  logic signed [31:0] x_momentum,
    input  logic               done,
    input  logic signed [31:0] y_momentum,
    input  logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending
);

    localparam int FB = 24;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd1 << FB;

    typedef struct packed {
        logic signed [31:0] py;
        hmsu_pkg::status_t  st;
    } solution_t;

    solution_t solutions_due[$];
    longint    mu_reg;
    longint    energy_reg;

    function automatic longint clamp(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    // rounded product, ties toward +inf
    function automatic longint qmul(longint a, longint b, int s);
        longint p;
        p = a * b + (64'sd1 <<< (s - 1));
        return clamp(p >>> s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint radius(longint dx, longint y);
        longint sq;
        sq = clamp(qmul(dx, dx, FB) + qmul(y, y, FB));
        return clamp(longint'(int_sqrt(longint'(unsigned'(sq)) << FB)));
    endfunction

    function automatic longint potential(longint mass, longint r);
        longint unsigned num;
        num = (longint'(unsigned'(mass)) << FB) + (longint'(unsigned'(r)) >> 1);
        return clamp(longint'(num / longint'(unsigned'(r))));
    endfunction

    function automatic solution_t solve_py(longint x, longint y, longint px);
        solution_t sol;
        longint mu, mu2, r1, r2, t1, t2, c, disc, root;
        mu   = (mu_reg > ONE) ? ONE : mu_reg;
        mu2  = ONE - mu;
        r1   = radius(clamp(x - mu2), y);
        r2   = radius(clamp(x + mu), y);
        t1   = (r1 == 0) ? WMAX : potential(mu, r1);
        t2   = (r2 == 0) ? WMAX : potential(mu2, r2);
        c    = clamp(qmul(px, px, FB + 1) + qmul(y, px, FB));
        c    = clamp(c - t1);
        c    = clamp(c - t2);
        c    = clamp(c - energy_reg);
        disc = clamp(qmul(x, x, FB) - clamp(c * 2));
        sol.py = '0;
        if (r1 == 0 || r2 == 0) begin
            sol.st = hmsu_pkg::ST_ON_PRIMARY;
        end else if (disc < 0) begin
            sol.st = hmsu_pkg::ST_NEG_DISC;
        end else begin
            sol.st = hmsu_pkg::ST_OK;
            root = clamp(longint'(int_sqrt(longint'(unsigned'(disc)) << FB)));
            sol.py = 32'(clamp(x - root));
        end
        return sol;
    endfunction

    assign pending = solutions_due.size();

    always @(posedge clk or negedge rst_n) begin
        solution_t want;
        if (!rst_n) begin
            mu_reg     <= 0;
            energy_reg <= 0;
            fail_count <= 0;
            solutions_due.delete();
        end else begin
            if (done) begin
                if (solutions_due.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result py=%0d st=%0d", y_momentum, status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = solutions_due.pop_front();
                    if (want.py !== y_momentum || want.st !== status) begin
                        if (fail_count < 10)
                            $display("mismatch: exp py=%0d st=%0d, got py=%0d st=%0d",
                                     want.py, want.st, y_momentum, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                solutions_due.push_back(solve_py(x_pos, y_pos, x_momentum));
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'(4 * hmsu_pkg::REG_MASS_RATIO))
                    mu_reg <= longint'(pwdata[24:0]);
                else if (paddr == 3'(4 * hmsu_pkg::REG_ENERGY))
                    energy_reg <= longint'(signed'(pwdata));
            end
        end
    end
endmodule

@@ dv/tb_hamiltonian_momentum_solver_unit.sv @@
`timescale 1ns / 1ps

module tb_hamiltonian_momentum_solver_unit;

    localparam int LATENCY  = 113;
    localparam int WATCHDOG = 20000;
    localparam logic signed [31:0] Q_ONE  = 32'sh0100_0000;
    localparam logic signed [31:0] Q_HALF = 32'sh0080_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] x_pos = '0, y_pos = '0, x_momentum = '0;
    logic               done;
    logic signed [31:0] y_momentum;
    logic [1:0]         status;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;
    bit                 allow_idle = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hamiltonian_momentum_solver_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_pos(x_pos), .y_pos(y_pos), .x_momentum(x_momentum),
        .done(done), .y_momentum(y_momentum), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // checker predicts every point transfer and scores the done strobes
    hmsu_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_pos(x_pos), .y_pos(y_pos), .x_momentum(x_momentum),
        .done(done), .y_momentum(y_momentum), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog: cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // hold start low while idling; n sets how long
    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // one point transfer; start stays high into the next call
    task automatic send_point(logic signed [31:0] xv, logic signed [31:0] yv,
                              logic signed [31:0] pv);
        if (allow_idle && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 10));
        @(negedge clk);
        start      <= 1'b1;
        x_pos      <= xv;
        y_pos      <= yv;
        x_momentum <= pv;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic reg_write(hmsu_pkg::cfg_reg_t idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain all outstanding results, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // mostly moderate coordinates (within +-4.0) so many points solve,
    // with some extremes and raw 32-bit noise
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return '0;
                endcase
            end
            2: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    initial
    begin
        logic [31:0] mu_set [6];
        logic [31:0] en_set [6];
        mu_set = '{32'h0000_0000, 32'h0100_0000, 32'h01FF_FFFF, 32'h0000_2000,
                   32'h0080_0000, 32'h0000_0000};
        en_set = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFE80_0000,
                   32'h0000_0000, 32'h0000_0000};
        mu_set[4] = $urandom_range(0, 32'h0100_0000);
        en_set[4] = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0300_0000;
        mu_set[5] = $urandom & 32'h01FF_FFFF;
        en_set[5] = $urandom;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed points at reset config: primaries at x = 1 and x = 0
        send_point('0, '0, '0);                 // on the heavy primary
        send_point(Q_ONE, '0, '0);              // on the light primary
        send_point(Q_ONE, 32'sd1, '0);          // distance rounds to zero
        send_point(Q_HALF, '0, '0);
        send_point('0, Q_ONE, '0);
        send_point(Q_HALF, Q_HALF, 32'sh0500_0000); // large px, discriminant goes negative
        send_point(Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MIN, '0);
        send_point(Q_MIN, '0, Q_MAX);
        send_point('0, Q_MAX, Q_MIN);
        send_point(-Q_ONE, -Q_ONE, Q_ONE);
        send_point(32'sh0200_0000, '0, -Q_HALF);
        send_point(-32'sh0300_0000, Q_HALF, Q_HALF);
        drain();
        reg_write(hmsu_pkg::REG_MASS_RATIO, 32'h0100_0000);
        reg_write(hmsu_pkg::REG_ENERGY, 32'hFE00_0000);
        send_point('0, '0, '0);
        send_point(-Q_ONE, '0, '0);             // on primary at x = -mu
        send_point(Q_HALF, Q_HALF, '0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            reg_write(hmsu_pkg::REG_MASS_RATIO, mu_set[ph]);
            reg_write(hmsu_pkg::REG_ENERGY, en_set[ph]);
            allow_idle = (ph != 5);
            for (int k = 0; k < 175; k++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
